// File: rtl/core/olmr_pkg.sv
// Shared types, constants and helper functions of the obstacle-limited motor ramp.
`timescale 1ns / 1ps

package olmr_pkg;

    localparam int SAMPLE_W  = 9;
    localparam int DUTY_W    = 8;
    localparam int STEP_W    = 6;
    localparam int DIST_W    = 8;
    localparam int DEN_W     = 16;
    localparam int QUO_W     = 20;
    localparam int DIV_CNT_W = $clog2(QUO_W + 1);
    localparam int IN_W      = 24;
    localparam int OUT_W     = 40;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [QUO_W-1:0]    DIST_NUM   = QUO_W'(946200);
    localparam logic [DEN_W-1:0]    DIST_OFS   = DEN_W'(1692);
    localparam logic [SAMPLE_W-1:0] SAMPLE_LOW = SAMPLE_W'(16);
    localparam logic [DIST_W-1:0]   DIST_MIN   = DIST_W'(19);
    localparam logic [DIST_W-1:0]   DIST_MAX   = DIST_W'(151);

    localparam logic [15:0]       K_FWD        = 16'd150;
    localparam logic [15:0]       K_REV        = 16'd225;
    localparam logic [DUTY_W-1:0] DUTY_SNAP    = DUTY_W'(250);
    localparam logic [DUTY_W-1:0] DUTY_HIGH    = DUTY_W'(240);
    localparam logic [DUTY_W-1:0] DUTY_NEAR    = DUTY_W'(30);
    localparam logic [DUTY_W-1:0] DUTY_FAR     = DUTY_W'(50);

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(5);
    localparam logic [DIST_W-1:0] SLOW_RESET = DIST_W'(40);

    localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_STEP = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_DIST = 1'b1;

    localparam logic [1:0] DRIVE_FWD = 2'd1;
    localparam logic [1:0] DRIVE_REV = 2'd2;
    localparam logic [1:0] LIFT_OFF  = 2'd0;
    localparam logic [1:0] LIFT_DOWN = 2'd1;
    localparam logic [1:0] LIFT_UP   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_FRONT,
        ST_WAIT_FRONT,
        ST_DIV_REAR,
        ST_WAIT_REAR,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic              drive_fwd_line;
        logic              drive_rev_line;
        logic [DUTY_W-1:0] drive_duty;
        logic              lift_down_line;
        logic              lift_up_line;
        logic [DUTY_W-1:0] lift_duty;
    } ramp_out_t;

    function automatic logic [DUTY_W-1:0] sat_add(input logic [DUTY_W-1:0] a,
                                                  input logic [DUTY_W-1:0] b);
        logic [DUTY_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[DUTY_W] ? {DUTY_W{1'b1}} : sum[DUTY_W-1:0];
    endfunction

    function automatic logic [DUTY_W-1:0] sat_sub(input logic [DUTY_W-1:0] a,
                                                  input logic [DUTY_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    // Clamp a quotient to the sensor range; tiny samples read as the minimum.
    function automatic logic [DIST_W-1:0] to_cm(input logic [SAMPLE_W-1:0] s,
                                                input logic [QUO_W-1:0]    q);
        logic [DIST_W-1:0] r;
        if (s <= SAMPLE_LOW)
        begin
            r = DIST_MIN;
        end
        else if (q > QUO_W'(DIST_MAX))
        begin
            r = DIST_MAX;
        end
        else if (q < QUO_W'(DIST_MIN))
        begin
            r = DIST_MIN;
        end
        else
        begin
            r = q[DIST_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/olmr_div.sv
// Iterative restoring divider: fixed numerator over a 16-bit divisor, one bit a cycle.
`timescale 1ns / 1ps

module olmr_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [olmr_pkg::DEN_W-1:0]     den,
    output logic                           done,
    output logic [olmr_pkg::QUO_W-1:0]     quo
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [olmr_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [olmr_pkg::DEN_W-1:0]        rem_reg, rem_next;
    logic [olmr_pkg::DEN_W-1:0]        den_reg, den_next;
    logic [olmr_pkg::QUO_W-1:0]        work_reg, work_next;
    logic [olmr_pkg::DEN_W:0]          rem_sh;
    logic [olmr_pkg::DEN_W:0]          diff;
    logic                              ge;

    always_comb
    begin
        rem_sh    = {rem_reg, work_reg[olmr_pkg::QUO_W-1]};
        diff      = rem_sh - {1'b0, den_reg};
        ge        = (rem_sh >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        work_next = work_reg;
        if (busy_reg)
        begin
            // shift one quotient bit in, restore when the trial subtract fails
            rem_next  = ge ? diff[olmr_pkg::DEN_W-1:0] : rem_sh[olmr_pkg::DEN_W-1:0];
            work_next = {work_reg[olmr_pkg::QUO_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == olmr_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = olmr_pkg::DIV_CNT_W'(olmr_pkg::QUO_W);
            rem_next  = '0;
            den_next  = den;
            work_next = olmr_pkg::DIST_NUM;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        work_reg <= work_next;
    end

    assign done = done_reg;
    assign quo  = work_reg;

endmodule

// File: rtl/core/olmr_ramp.sv
// Next duty levels and bridge lines for one control tick.
`timescale 1ns / 1ps

module olmr_ramp (
    input  logic [olmr_pkg::DUTY_W-1:0] drive_level,
    input  logic [olmr_pkg::DUTY_W-1:0] lift_level,
    input  logic [olmr_pkg::DIST_W-1:0] front_distance,
    input  logic [olmr_pkg::DIST_W-1:0] rear_distance,
    input  logic [1:0]                  drive_mode,
    input  logic [1:0]                  lift_mode,
    input  logic [olmr_pkg::STEP_W-1:0] ramp_step,
    input  logic [olmr_pkg::DIST_W-1:0] slow_distance,
    output olmr_pkg::ramp_out_t         res
);

    logic [olmr_pkg::DIST_W-1:0] d;
    logic [olmr_pkg::DUTY_W-1:0] step;
    logic [olmr_pkg::DUTY_W-1:0] dec;
    logic [15:0]                 lhs;
    logic [15:0]                 rhs;
    logic [olmr_pkg::DUTY_W-1:0] drive_new;
    logic                        moving;

    always_comb
    begin
        d      = (drive_mode == olmr_pkg::DRIVE_REV) ? rear_distance : front_distance;
        step   = olmr_pkg::DUTY_W'(ramp_step);
        dec    = olmr_pkg::DUTY_W'({2'b00, ramp_step} + {1'b0, ramp_step, 1'b0});
        lhs    = {d, 8'h00} - 16'(d);
        rhs    = 16'(drive_level) *
                 ((drive_mode == olmr_pkg::DRIVE_REV) ? olmr_pkg::K_REV : olmr_pkg::K_FWD);
        moving = (drive_mode == olmr_pkg::DRIVE_FWD) || (drive_mode == olmr_pkg::DRIVE_REV);

        // obstacle close: brake; room ahead: climb; else coast down
        if (d < slow_distance)
        begin
            drive_new = (drive_level < olmr_pkg::DUTY_NEAR) ? '0
                        : olmr_pkg::sat_sub(drive_level, dec);
        end
        else if (lhs > rhs)
        begin
            drive_new = (drive_level >= olmr_pkg::DUTY_HIGH) ? olmr_pkg::DUTY_SNAP
                        : olmr_pkg::sat_add(drive_level, step);
        end
        else
        begin
            drive_new = (drive_level < olmr_pkg::DUTY_FAR) ? '0
                        : olmr_pkg::sat_sub(drive_level, dec);
        end

        res.drive_fwd_line = (drive_mode == olmr_pkg::DRIVE_FWD);
        res.drive_rev_line = (drive_mode == olmr_pkg::DRIVE_REV);
        res.drive_duty     = moving ? drive_new : '0;
        res.lift_down_line = (lift_mode == olmr_pkg::LIFT_DOWN);
        res.lift_up_line   = (lift_mode == olmr_pkg::LIFT_UP);
        if (lift_mode == olmr_pkg::LIFT_OFF)
        begin
            res.lift_duty = '0;
        end
        else if (lift_level < olmr_pkg::DUTY_SNAP)
        begin
            res.lift_duty = olmr_pkg::sat_add(lift_level, step);
        end
        else
        begin
            res.lift_duty = olmr_pkg::sat_sub(lift_level, step);
        end
    end

endmodule

// File: rtl/core/obstacle_limited_motor_ramp_core.sv
// Top level of the obstacle-limited motor ramp: handshake, sequencer and state.
`timescale 1ns / 1ps
//
// One input word is one control tick: two infrared samples and the drive and
// lift modes. One output word follows per tick: bridge lines, the new drive
// and lift duties and both clamped distances in cm.
// Input word  (s_*): accepted when s_tvalid and s_tready are high at a clock edge.
// Output word (m_*): taken when m_tvalid and m_tready are high.
// Config: cfg_we writes cfg_wdata to register cfg_addr (0 ramp_step,
// 1 slow_distance) at the edge; write only while the block is idle.
// Timing: both distances go through one shared 20-step restoring divider,
// front sample then rear; the divider's loop yields one quotient bit per
// cycle. s_tready is high only while the sequencer is idle, so one tick
// is in work at a time.
// A finished word waits in the output register; a new input word is still
// accepted, and its update stalls until the previous word is taken.
// Reset: duties clear to 0, ramp_step to 5, slow_distance to 40, no word is
// pending and the block is ready at once.

module obstacle_limited_motor_ramp_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // front_sample[8:0], rear_sample[17:9], drive_mode[19:18], lift_mode[21:20]
    input  logic [olmr_pkg::IN_W-1:0]         s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // drive_fwd_line[0], drive_rev_line[1], drive_duty[9:2], lift_down_line[10],
    // lift_up_line[11], lift_duty[19:12], front_distance[27:20], rear_distance[35:28]
    output logic [olmr_pkg::OUT_W-1:0]        m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [olmr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [olmr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    olmr_pkg::state_t                state_reg, state_next;
    logic [olmr_pkg::SAMPLE_W-1:0]   front_reg, front_next;
    logic [olmr_pkg::SAMPLE_W-1:0]   rear_reg, rear_next;
    logic [1:0]                      dmode_reg, dmode_next;
    logic [1:0]                      lmode_reg, lmode_next;
    logic [olmr_pkg::DIST_W-1:0]     fdist_reg, fdist_next;
    logic [olmr_pkg::DIST_W-1:0]     rdist_reg, rdist_next;
    logic [olmr_pkg::DUTY_W-1:0]     drive_level_reg, drive_level_next;
    logic [olmr_pkg::DUTY_W-1:0]     lift_level_reg, lift_level_next;
    logic [olmr_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [olmr_pkg::DIST_W-1:0]     slow_reg, slow_next;
    logic                            ovalid_reg, ovalid_next;
    logic [olmr_pkg::OUT_W-1:0]      odata_reg, odata_next;

    logic                            div_start;
    logic [olmr_pkg::SAMPLE_W-1:0]   div_sample;
    logic [olmr_pkg::DEN_W-1:0]      div_den;
    logic                            div_done;
    logic [olmr_pkg::QUO_W-1:0]      div_quo;
    olmr_pkg::ramp_out_t             ramp_res;

    // divisor 100*s - 1692 from shifts and adds
    always_comb
    begin
        div_sample = (state_reg == olmr_pkg::ST_DIV_REAR) ? rear_reg : front_reg;
        div_den    = ({1'b0, div_sample, 6'b0} + {2'b0, div_sample, 5'b0}
                     + {5'b0, div_sample, 2'b0}) - olmr_pkg::DIST_OFS;
    end

    olmr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    olmr_ramp u_ramp (
        .drive_level    (drive_level_reg),
        .lift_level     (lift_level_reg),
        .front_distance (fdist_reg),
        .rear_distance  (rdist_reg),
        .drive_mode     (dmode_reg),
        .lift_mode      (lmode_reg),
        .ramp_step      (step_reg),
        .slow_distance  (slow_reg),
        .res            (ramp_res)
    );

    always_comb
    begin
        state_next       = state_reg;
        front_next       = front_reg;
        rear_next        = rear_reg;
        dmode_next       = dmode_reg;
        lmode_next       = lmode_reg;
        fdist_next       = fdist_reg;
        rdist_next       = rdist_reg;
        drive_level_next = drive_level_reg;
        lift_level_next  = lift_level_reg;
        step_next        = step_reg;
        slow_next        = slow_reg;
        ovalid_next      = ovalid_reg;
        odata_next       = odata_reg;
        div_start        = 1'b0;
        s_tready         = (state_reg == olmr_pkg::ST_IDLE);

        if (cfg_we)
        begin
            unique case (cfg_addr)
                olmr_pkg::CFG_RAMP_STEP: step_next = cfg_wdata[olmr_pkg::STEP_W-1:0];
                olmr_pkg::CFG_SLOW_DIST: slow_next = cfg_wdata[olmr_pkg::DIST_W-1:0];
                default: ;
            endcase
        end

        // drop the output word once taken
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            olmr_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    front_next = s_tdata[8:0];
                    rear_next  = s_tdata[17:9];
                    dmode_next = s_tdata[19:18];
                    lmode_next = s_tdata[21:20];
                    state_next = olmr_pkg::ST_DIV_FRONT;
                end
            end
            olmr_pkg::ST_DIV_FRONT:
            begin
                div_start  = 1'b1;
                state_next = olmr_pkg::ST_WAIT_FRONT;
            end
            olmr_pkg::ST_WAIT_FRONT:
            begin
                if (div_done)
                begin
                    fdist_next = olmr_pkg::to_cm(front_reg, div_quo);
                    state_next = olmr_pkg::ST_DIV_REAR;
                end
            end
            olmr_pkg::ST_DIV_REAR:
            begin
                div_start  = 1'b1;
                state_next = olmr_pkg::ST_WAIT_REAR;
            end
            olmr_pkg::ST_WAIT_REAR:
            begin
                if (div_done)
                begin
                    rdist_next = olmr_pkg::to_cm(rear_reg, div_quo);
                    state_next = olmr_pkg::ST_UPDATE;
                end
            end
            olmr_pkg::ST_UPDATE:
            begin
                // hold the update until the output register is free
                if (!ovalid_reg || m_tready)
                begin
                    drive_level_next = ramp_res.drive_duty;
                    lift_level_next  = ramp_res.lift_duty;
                    ovalid_next      = 1'b1;
                    odata_next       = {4'b0000, rdist_reg, fdist_reg,
                                        ramp_res.lift_duty, ramp_res.lift_up_line,
                                        ramp_res.lift_down_line, ramp_res.drive_duty,
                                        ramp_res.drive_rev_line, ramp_res.drive_fwd_line};
                    state_next       = olmr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = olmr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= olmr_pkg::ST_IDLE;
            drive_level_reg <= '0;
            lift_level_reg  <= '0;
            step_reg        <= olmr_pkg::STEP_RESET;
            slow_reg        <= olmr_pkg::SLOW_RESET;
            ovalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            drive_level_reg <= drive_level_next;
            lift_level_reg  <= lift_level_next;
            step_reg        <= step_next;
            slow_reg        <= slow_next;
            ovalid_reg      <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        rear_reg  <= rear_next;
        dmode_reg <= dmode_next;
        lmode_reg <= lmode_next;
        fdist_reg <= fdist_next;
        rdist_reg <= rdist_next;
        odata_reg <= odata_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

endmodule
